// ===== design/thcq_pkg.sv =====
// shared types and codes for the two-hop connection query block
package thcq_pkg;

   localparam int NODE_W = 6;
   localparam int SLOT_W = 4;
   localparam int DEG_W  = 5;
   localparam int OP_W   = 2;
   localparam int ANS_W  = 2;
   localparam int KIND_W = 2;

   // request operation codes
   localparam logic [OP_W-1:0] OP_SET_COUNT  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_SLOT = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY      = 2'd2;

   // answer codes
   localparam logic [ANS_W-1:0] ANS_DIRECT     = 2'd0;
   localparam logic [ANS_W-1:0] ANS_ONE_CHANGE = 2'd1;
   localparam logic [ANS_W-1:0] ANS_NONE       = 2'd2;

   // command kinds after classification
   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MISS  = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] other;
      logic [SLOT_W-1:0] slot;
      logic [DEG_W-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

// ===== design/thcq_ram.sv =====
// generic single-write single-read ram with registered read data
module thcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/thcq_front.sv =====
// request classification and two-entry command queue
module thcq_front import thcq_pkg::*; #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_DEGREE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [NODE_W-1:0] req_first_node,
   input  logic [NODE_W-1:0] req_second_node,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [DEG_W-1:0]  req_neighbor_count,
   input  logic              back_clearing,
   input  logic              pop,
   output head_type          head,
   output logic [1:0]        q_count
);

   cmd_type    q_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;

   cmd_type cls;
   logic    keep;
   logic    node_ok;
   logic    push;

   always_comb begin
      node_ok   = 32'(req_first_node) < MAX_NODES;
      cls.node  = req_first_node;
      cls.other = req_second_node;
      cls.slot  = req_slot;
      // saturate degree at row length
      cls.count = (32'(req_neighbor_count) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                           : req_neighbor_count;
      cls.kind  = KIND_MISS;
      keep      = 1'b0;
      case (req_operation)
         OP_SET_COUNT: begin
            cls.kind = KIND_SET;
            keep     = node_ok;
         end
         OP_WRITE_SLOT: begin
            cls.kind = KIND_WRITE;
            keep     = node_ok && (32'(req_slot) < MAX_DEGREE);
         end
         OP_QUERY: begin
            cls.kind = node_ok ? KIND_QUERY : KIND_MISS;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy = (count_ff == 2'd2) || back_clearing;
   assign push = start && !busy && keep;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head.valid = count_ff != 2'd0;
   assign head.cmd   = q_ff[rd_ptr_ff];
   assign q_count    = count_ff;

endmodule

// ===== design/thcq_back.sv =====
// command execution: table writes, degree clear and the two-hop scan sequencer
module thcq_back import thcq_pkg::*; #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_DEGREE = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  head_type         head,
   output logic             pop,
   output logic             clearing,
   output logic             rsp_valid,
   output logic [ANS_W-1:0] rsp_answer
);

   localparam int AW  = $clog2(MAX_NODES * MAX_DEGREE);
   localparam int NAW = $clog2(MAX_NODES);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_SRC_DEG   = 3'd2;
   localparam logic [2:0] S_DIRECT    = 3'd3;
   localparam logic [2:0] S_MID_FETCH = 3'd4;
   localparam logic [2:0] S_MID_DEG   = 3'd5;
   localparam logic [2:0] S_MID_SCAN  = 3'd6;

   function automatic logic [AW-1:0] nb_addr(input logic [NODE_W-1:0] n,
                                             input logic [DEG_W-1:0] i);
      logic [AW-1:0] base;
      base = AW'(AW'(n) * AW'(MAX_DEGREE));
      return base + AW'(i);
   endfunction

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [DEG_W-1:0] src_deg_ff, src_deg_in;
   logic [DEG_W-1:0] mid_deg_ff, mid_deg_in;
   logic [DEG_W-1:0] idx_ff, idx_in;
   logic [DEG_W-1:0] inner_ff, inner_in;
   logic [NODE_W-1:0] mid_ff, mid_in;
   logic [NAW-1:0]   clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ANS_W-1:0] rsp_answer_ff, rsp_answer_in;

   logic              deg_we;
   logic [NAW-1:0]    deg_waddr, deg_raddr;
   logic [DEG_W-1:0]  deg_wdata, deg_rdata;
   logic              nb_we;
   logic [AW-1:0]     nb_waddr, nb_raddr;
   logic [NODE_W-1:0] nb_wdata, nb_rdata;
   logic              do_adv;
   logic              outer_more, inner_more, direct_more;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      src_deg_in    = src_deg_ff;
      mid_deg_in    = mid_deg_ff;
      idx_in        = idx_ff;
      inner_in      = inner_ff;
      mid_in        = mid_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_answer_in = rsp_answer_ff;
      pop           = 1'b0;
      deg_we        = 1'b0;
      deg_waddr     = NAW'(head.cmd.node);
      deg_wdata     = head.cmd.count;
      deg_raddr     = NAW'(head.cmd.node);
      nb_we         = 1'b0;
      nb_waddr      = nb_addr(head.cmd.node, DEG_W'(head.cmd.slot));
      nb_wdata      = head.cmd.other;
      nb_raddr      = nb_addr(cmd_ff.node, '0);
      do_adv        = 1'b0;
      outer_more    = DEG_W'(idx_ff + 1'b1) < src_deg_ff;
      inner_more    = DEG_W'(inner_ff + 1'b1) < mid_deg_ff;
      direct_more   = outer_more;

      case (state_ff)
         S_CLEAR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_ff;
            deg_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == NAW'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               case (head.cmd.kind)
                  KIND_SET: begin
                     deg_we = 1'b1;
                  end
                  KIND_WRITE: begin
                     nb_we = 1'b1;
                  end
                  KIND_QUERY: begin
                     state_in = S_SRC_DEG;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_answer_in = ANS_NONE;
                  end
               endcase
            end
         end
         S_SRC_DEG: begin
            src_deg_in = deg_rdata;
            idx_in     = '0;
            if (deg_rdata == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ANS_NONE;
               state_in      = S_IDLE;
            end else begin
               state_in = S_DIRECT;
            end
         end
         S_DIRECT: begin
            if (nb_rdata == cmd_ff.other) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ANS_DIRECT;
               state_in      = S_IDLE;
            end else if (direct_more) begin
               idx_in   = DEG_W'(idx_ff + 1'b1);
               nb_raddr = nb_addr(cmd_ff.node, DEG_W'(idx_ff + 1'b1));
            end else begin
               // second pass over the source row, one neighbor at a time
               idx_in   = '0;
               state_in = S_MID_FETCH;
            end
         end
         S_MID_FETCH: begin
            mid_in = nb_rdata;
            if (32'(nb_rdata) < MAX_NODES) begin
               deg_raddr = NAW'(nb_rdata);
               state_in  = S_MID_DEG;
            end else begin
               do_adv = 1'b1;
            end
         end
         S_MID_DEG: begin
            mid_deg_in = deg_rdata;
            inner_in   = '0;
            if (deg_rdata == '0) begin
               do_adv = 1'b1;
            end else begin
               nb_raddr = nb_addr(mid_ff, '0);
               state_in = S_MID_SCAN;
            end
         end
         S_MID_SCAN: begin
            if (nb_rdata == cmd_ff.other) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ANS_ONE_CHANGE;
               state_in      = S_IDLE;
            end else if (inner_more) begin
               inner_in = DEG_W'(inner_ff + 1'b1);
               nb_raddr = nb_addr(mid_ff, DEG_W'(inner_ff + 1'b1));
            end else begin
               do_adv = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // move to the next intermediate node, or give up
      if (do_adv) begin
         if (outer_more) begin
            idx_in   = DEG_W'(idx_ff + 1'b1);
            nb_raddr = nb_addr(cmd_ff.node, DEG_W'(idx_ff + 1'b1));
            state_in = S_MID_FETCH;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_answer_in = ANS_NONE;
            state_in      = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      src_deg_ff    <= src_deg_in;
      mid_deg_ff    <= mid_deg_in;
      idx_ff        <= idx_in;
      inner_ff      <= inner_in;
      mid_ff        <= mid_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   thcq_ram #(
      .WIDTH(DEG_W),
      .DEPTH(MAX_NODES)
   ) u_degree_ram (
      .clock  (clock),
      .wr_en  (deg_we),
      .wr_addr(deg_waddr),
      .wr_data(deg_wdata),
      .rd_addr(deg_raddr),
      .rd_data(deg_rdata)
   );

   thcq_ram #(
      .WIDTH(NODE_W),
      .DEPTH(MAX_NODES * MAX_DEGREE)
   ) u_neighbor_ram (
      .clock  (clock),
      .wr_en  (nb_we),
      .wr_addr(nb_waddr),
      .wr_data(nb_wdata),
      .rd_addr(nb_raddr),
      .rd_data(nb_rdata)
   );

   assign clearing   = state_ff == S_CLEAR;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;

endmodule

// ===== design/two_hop_connection_query_top.sv =====
// top level of the two-hop connection query block
//
// an adjacency table with one row per node: a degree and up to MAX_DEGREE
// neighbor slots. a beat is taken on start while busy is low and either sets
// a row's degree (saturated at MAX_DEGREE), writes one neighbor slot, or
// queries a source/target pair. set and write beats give no response; a query
// gives exactly one response beat, rsp_valid high for a single cycle with
// rsp_answer = 0 direct link, 1 reachable through one intermediate node,
// 2 not reachable. responses cannot be held off by the receiver.
// after reset, busy stays high while the degree table is swept to zero. up
// to two beats queue in front of the execution unit; set and write are
// done straight from idle there, as is a query with an out-of-range source,
// and a full query reads the source degree, scans the source row for a
// direct link, then reads each neighbor's degree and scans its row, through
// the single read port of the neighbor table, which is read once per cycle.
// a query stops at the first match. slots inside a row's degree must be
// written before a query reads them.
module two_hop_connection_query_top import thcq_pkg::*; #(
   parameter int MAX_NODES  = 64,
   parameter int MAX_DEGREE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [NODE_W-1:0] req_first_node,
   input  logic [NODE_W-1:0] req_second_node,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [DEG_W-1:0]  req_neighbor_count,
   output logic              rsp_valid,
   output logic [ANS_W-1:0]  rsp_answer
);

   // queue head toward the execution unit and its pop back
   head_type   head;
   logic       pop;
   // degree sweep after reset holds off new beats
   logic       clearing;
   logic [1:0] q_count;

   // front: classify each beat, drop the ones that do nothing, queue the rest
   thcq_front #(
      .MAX_NODES (MAX_NODES),
      .MAX_DEGREE(MAX_DEGREE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .req_slot          (req_slot),
      .req_neighbor_count(req_neighbor_count),
      .back_clearing     (clearing),
      .pop               (pop),
      .head              (head),
      .q_count           (q_count)
   );

   // back: table writes and the query scan, one read of each table per cycle
   thcq_back #(
      .MAX_NODES (MAX_NODES),
      .MAX_DEGREE(MAX_DEGREE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_answer(rsp_answer)
   );

`ifndef SYNTHESIS
   // no response can come out while the degree table is being swept
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("response during degree clear");

   // the queue never holds more than its two entries
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("command queue overflow");

   // a pop only happens with something in the queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_count != 2'd0))
      else $error("pop from empty command queue");
`endif

endmodule
